/* design/rgbhsv_pkg.sv */
`timescale 1ns / 1ps

package rgbhsv_pkg;

    // channel and fraction widths
    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;

    // divider geometry: the quotient may reach one full turn, so one extra bit
    localparam int QUOT_BITS  = FRACTION_BITS + 1;
    localparam int DIVR_BITS  = CHANNEL_BITS + 4;
    localparam int DIVD_BITS  = DIVR_BITS + QUOT_BITS;
    localparam int NUM_BITS   = CHANNEL_BITS + 3;
    localparam int DIV_STAGES = QUOT_BITS;

    typedef logic [CHANNEL_BITS-1:0]  chan_t;
    typedef logic [FRACTION_BITS-1:0] frac_t;
    typedef logic [NUM_BITS-1:0]      num_t;
    typedef logic [DIVR_BITS-1:0]     divr_t;
    typedef logic [DIVD_BITS-1:0]     divd_t;
    typedef logic [QUOT_BITS-1:0]     quot_t;

    // one lane of the restoring divider: partial remainder, dividend bits
    // still to consume shifted together with the quotient bits, divisor
    typedef struct packed {
        divr_t rem;
        quot_t sh;
        divr_t divr;
    } div_lane_t;

    // one item in flight through the divider
    typedef struct packed {
        div_lane_t hue;
        div_lane_t sat;
        chan_t     bright;
    } div_item_t;

    // finished result
    typedef struct packed {
        frac_t hue;
        frac_t sat;
        chan_t bright;
    } hsv_t;

endpackage

/* design/rgbhsv_if.sv */
`timescale 1ns / 1ps

// pixel channel: red, green, blue
interface rgbhsv_pix_if;
    logic                valid;
    logic                ready;
    rgbhsv_pkg::chan_t   red_in;
    rgbhsv_pkg::chan_t   green_in;
    rgbhsv_pkg::chan_t   blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

// result channel: hue, saturation, brightness
interface rgbhsv_hsv_if;
    logic                valid;
    logic                ready;
    rgbhsv_pkg::frac_t   hue_out;
    rgbhsv_pkg::frac_t   saturation_out;
    rgbhsv_pkg::chan_t   brightness_out;

    modport source (output valid, output hue_out, output saturation_out,
                    output brightness_out, input ready);
    modport sink   (input valid, input hue_out, input saturation_out,
                    input brightness_out, output ready);
endinterface

/* design/rgb_to_hsv_converter.sv */
// Pipeline: 4 preparation stages, 17 divider stages of one quotient bit each, output
// register. Throughput: one pixel per cycle while not stalled; the 17-stage restoring
// divider sets the depth.
// Stalls: a full output skid entry freezes the whole pipeline until the result drains.
// Reset: rst_n clears all valid bits asynchronously; no data is held over.
`timescale 1ns / 1ps

module rgb_to_hsv_converter (
    input  logic          clk,
    input  logic          rst_n,
    rgbhsv_pix_if.sink    pixel,
    rgbhsv_hsv_if.source  hsv
);

    logic                  en;
    logic                  prep_valid;
    rgbhsv_pkg::div_item_t prep_item;
    logic                  div_valid;
    rgbhsv_pkg::div_item_t div_item;
    rgbhsv_pkg::hsv_t      div_hsv;

    // max, min, sector and dividend setup
    rgbhsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .pixel     (pixel),
        .out_valid (prep_valid),
        .out_item  (prep_item)
    );

    // hue and saturation division
    rgbhsv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_item   (prep_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    // a hue quotient of one full turn drops its top bit and wraps to 0
    assign div_hsv.hue    = div_item.hue.sh[rgbhsv_pkg::FRACTION_BITS-1:0];
    assign div_hsv.sat    = div_item.sat.sh[rgbhsv_pkg::FRACTION_BITS-1:0];
    assign div_hsv.bright = div_item.bright;

    // output register with skid entry
    rgbhsv_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .in_ready (en),
        .in_hsv   (div_hsv),
        .hsv      (hsv)
    );

`ifndef SYNTH
    // input only waits behind a result held at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> hsv.valid)
    else $error("input stalled with no result at output");

    // input ready drops only after the output was refused
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pixel.ready) |-> $past(hsv.valid && !hsv.ready))
    else $error("input stalled without output backpressure");

    // zero saturation means a grey pixel, whose hue is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid && hsv.saturation_out == '0 |-> hsv.hue_out == '0)
    else $error("grey pixel with nonzero hue");

    // black pixel has no saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv.valid && hsv.brightness_out == '0 |-> hsv.saturation_out == '0)
    else $error("black pixel with nonzero saturation");
`endif

endmodule

/* design/rgbhsv_prep.sv */
`timescale 1ns / 1ps

module rgbhsv_prep (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    rgbhsv_pix_if.sink              pixel,
    output logic                    out_valid,
    output rgbhsv_pkg::div_item_t   out_item
);

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef logic signed [rgbhsv_pkg::CHANNEL_BITS:0]   diff_t;
    typedef logic signed [rgbhsv_pkg::CHANNEL_BITS+3:0] snum_t;

    typedef struct packed {
        rgbhsv_pkg::chan_t mx;
        rgbhsv_pkg::chan_t mn;
        sector_t           sector;
        diff_t             diff;
    } s1_t;

    typedef struct packed {
        rgbhsv_pkg::chan_t mx;
        rgbhsv_pkg::chan_t spread;
        sector_t           sector;
        diff_t             diff;
    } s2_t;

    typedef struct packed {
        rgbhsv_pkg::chan_t   mx;
        logic                grey;
        rgbhsv_pkg::num_t    num;
        rgbhsv_pkg::num_t    six_d;
        rgbhsv_pkg::divr_t   hue_divr;
        rgbhsv_pkg::divd_t   sat_divd;
    } s3_t;

    logic [3:0]            v_reg;
    s1_t                   s1_reg, s1_next;
    s2_t                   s2_reg, s2_next;
    s3_t                   s3_reg, s3_next;
    rgbhsv_pkg::div_item_t s4_reg, s4_next;

    rgbhsv_pkg::num_t      base;
    snum_t                 num_wide;
    rgbhsv_pkg::divd_t     hue_divd;
    rgbhsv_pkg::divd_t     sat_divd;
    rgbhsv_pkg::divr_t     hue_divr;
    rgbhsv_pkg::divr_t     sat_divr;

    assign pixel.ready = en;

    // stage 1: largest, smallest, sector and signed difference
    always_comb
    begin
        s1_next.mn = pixel.red_in;
        if (pixel.green_in < s1_next.mn)
        begin
            s1_next.mn = pixel.green_in;
        end
        if (pixel.blue_in < s1_next.mn)
        begin
            s1_next.mn = pixel.blue_in;
        end
        if (pixel.red_in >= pixel.green_in && pixel.red_in >= pixel.blue_in)
        begin
            s1_next.sector = SECTOR_RED;
            s1_next.mx     = pixel.red_in;
            s1_next.diff   = $signed({1'b0, pixel.green_in}) - $signed({1'b0, pixel.blue_in});
        end
        else if (pixel.green_in >= pixel.blue_in)
        begin
            s1_next.sector = SECTOR_GREEN;
            s1_next.mx     = pixel.green_in;
            s1_next.diff   = $signed({1'b0, pixel.blue_in}) - $signed({1'b0, pixel.red_in});
        end
        else
        begin
            s1_next.sector = SECTOR_BLUE;
            s1_next.mx     = pixel.blue_in;
            s1_next.diff   = $signed({1'b0, pixel.red_in}) - $signed({1'b0, pixel.green_in});
        end
    end

    // stage 2: spread
    always_comb
    begin
        s2_next.mx     = s1_reg.mx;
        s2_next.spread = s1_reg.mx - s1_reg.mn;
        s2_next.sector = s1_reg.sector;
        s2_next.diff   = s1_reg.diff;
    end

    // stage 3: hue numerator with wrap, hue divisor, saturation dividend
    always_comb
    begin
        s3_next.mx    = s2_reg.mx;
        s3_next.grey  = (s2_reg.spread == '0);
        s3_next.six_d = (rgbhsv_pkg::num_t'(s2_reg.spread) << 2)
                      + (rgbhsv_pkg::num_t'(s2_reg.spread) << 1);
        case (s2_reg.sector)
            SECTOR_RED:   base = (s2_reg.diff < 0) ? s3_next.six_d : '0;
            SECTOR_GREEN: base = rgbhsv_pkg::num_t'(s2_reg.spread) << 1;
            SECTOR_BLUE:  base = rgbhsv_pkg::num_t'(s2_reg.spread) << 2;
            default:      base = '0;
        endcase
        num_wide    = $signed({1'b0, base}) + s2_reg.diff;
        s3_next.num = num_wide[rgbhsv_pkg::NUM_BITS-1:0];
        s3_next.hue_divr = (rgbhsv_pkg::divr_t'(s2_reg.spread) << 3)
                         + (rgbhsv_pkg::divr_t'(s2_reg.spread) << 2);
        // 2 * spread * (2^F - 1) + mx, the rounding term for a 2*mx divisor
        s3_next.sat_divd = (rgbhsv_pkg::divd_t'(s2_reg.spread) << rgbhsv_pkg::QUOT_BITS)
                         - (rgbhsv_pkg::divd_t'(s2_reg.spread) << 1)
                         + rgbhsv_pkg::divd_t'(s2_reg.mx);
    end

    // stage 4: hue dividend, grey override, split into divider lanes
    always_comb
    begin
        hue_divd = (rgbhsv_pkg::divd_t'(s3_reg.num) << rgbhsv_pkg::QUOT_BITS)
                 + rgbhsv_pkg::divd_t'(s3_reg.six_d);
        sat_divd = s3_reg.sat_divd;
        hue_divr = s3_reg.hue_divr;
        sat_divr = rgbhsv_pkg::divr_t'({s3_reg.mx, 1'b0});
        // grey pixel: 0 over 1 gives zero hue and saturation
        if (s3_reg.grey)
        begin
            hue_divd = '0;
            sat_divd = '0;
            hue_divr = rgbhsv_pkg::divr_t'(1);
            sat_divr = rgbhsv_pkg::divr_t'(1);
        end
        s4_next.hue.rem  = hue_divd[rgbhsv_pkg::DIVD_BITS-1:rgbhsv_pkg::QUOT_BITS];
        s4_next.hue.sh   = hue_divd[rgbhsv_pkg::QUOT_BITS-1:0];
        s4_next.hue.divr = hue_divr;
        s4_next.sat.rem  = sat_divd[rgbhsv_pkg::DIVD_BITS-1:rgbhsv_pkg::QUOT_BITS];
        s4_next.sat.sh   = sat_divd[rgbhsv_pkg::QUOT_BITS-1:0];
        s4_next.sat.divr = sat_divr;
        s4_next.bright   = s3_reg.mx;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], pixel.valid};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_item  = s4_reg;

endmodule

/* design/rgbhsv_div.sv */
`timescale 1ns / 1ps

module rgbhsv_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  rgbhsv_pkg::div_item_t   in_item,
    output logic                    out_valid,
    output rgbhsv_pkg::div_item_t   out_item
);

    logic [rgbhsv_pkg::DIV_STAGES-1:0] v_reg;
    rgbhsv_pkg::div_item_t             item_reg  [rgbhsv_pkg::DIV_STAGES];
    rgbhsv_pkg::div_item_t             stage_in  [rgbhsv_pkg::DIV_STAGES];
    rgbhsv_pkg::div_item_t             item_next [rgbhsv_pkg::DIV_STAGES];

    // one restoring step: bring down the next dividend bit, subtract if it fits
    function automatic rgbhsv_pkg::div_lane_t div_step(input rgbhsv_pkg::div_lane_t lane);
        logic [rgbhsv_pkg::DIVR_BITS:0] trial;
        logic [rgbhsv_pkg::DIVR_BITS:0] diff;
        logic                           fits;
        rgbhsv_pkg::div_lane_t          res;
        trial    = {lane.rem, lane.sh[rgbhsv_pkg::QUOT_BITS-1]};
        fits     = (trial >= {1'b0, lane.divr});
        diff     = trial - {1'b0, lane.divr};
        res.divr = lane.divr;
        res.rem  = fits ? diff[rgbhsv_pkg::DIVR_BITS-1:0] : trial[rgbhsv_pkg::DIVR_BITS-1:0];
        res.sh   = {lane.sh[rgbhsv_pkg::QUOT_BITS-2:0], fits};
        return res;
    endfunction

    // stage inputs and one quotient bit per stage for both lanes
    always_comb
    begin
        stage_in[0] = in_item;
        for (int i = 1; i < rgbhsv_pkg::DIV_STAGES; i++)
        begin
            stage_in[i] = item_reg[i-1];
        end
        for (int i = 0; i < rgbhsv_pkg::DIV_STAGES; i++)
        begin
            item_next[i].hue    = div_step(stage_in[i].hue);
            item_next[i].sat    = div_step(stage_in[i].sat);
            item_next[i].bright = stage_in[i].bright;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[rgbhsv_pkg::DIV_STAGES-2:0], in_valid};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < rgbhsv_pkg::DIV_STAGES; i++)
            begin
                item_reg[i] <= item_next[i];
            end
        end
    end

    assign out_valid = v_reg[rgbhsv_pkg::DIV_STAGES-1];
    assign out_item  = item_reg[rgbhsv_pkg::DIV_STAGES-1];

endmodule

/* design/rgbhsv_out.sv */
`timescale 1ns / 1ps

module rgbhsv_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rgbhsv_pkg::hsv_t   in_hsv,
    rgbhsv_hsv_if.source       hsv
);

    logic              out_v_reg;
    logic              skid_v_reg;
    rgbhsv_pkg::hsv_t  out_reg;
    rgbhsv_pkg::hsv_t  skid_reg;
    logic              slot_free;

    // upstream only waits once the skid entry holds a result
    assign in_ready  = !skid_v_reg;
    assign slot_free = !out_v_reg || hsv.ready;

    // output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_v_reg  <= skid_v_reg || in_valid;
            skid_v_reg <= 1'b0;
        end
        else if (in_valid && !skid_v_reg)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            out_reg <= skid_v_reg ? skid_reg : in_hsv;
        end
        if (!slot_free && in_valid && !skid_v_reg)
        begin
            skid_reg <= in_hsv;
        end
    end

    assign hsv.valid          = out_v_reg;
    assign hsv.hue_out        = out_reg.hue;
    assign hsv.saturation_out = out_reg.sat;
    assign hsv.brightness_out = out_reg.bright;

endmodule
